// ===== design/qph_pkg.sv =====
// Shared types and constants for the quadratic-probe hash set.
// No dependencies.
package qph_pkg;

  localparam int SLOTS  = 1024;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int SIZE_W = 11;
  localparam int KEY_W  = 31;
  localparam int DIV_W  = $clog2(KEY_W);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(SLOTS);

  // config register byte address
  localparam logic [2:0] REG_TABLE_SIZE = 3'd0;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_MISSING = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_PROBE,
    ST_RESULT
  } state_t;

endpackage

// ===== design/quadratic_probe_hash_set.sv =====
// Quadratic-probe hash set: one slot memory (used flag + key), bit-serial modulo, probe walker.
// Throughput: one word at a time; one probe per cycle through the single-read-port slot
// memory. Reset: table_size returns to 1024; a clearing pass over every slot zeroes the
// used flags, no word is accepted until it ends. Depends on qph_pkg.
module quadratic_probe_hash_set (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  kind,
  input  logic [qph_pkg::KEY_W-1:0]   key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [qph_pkg::ADDR_W-1:0]  position
);
  import qph_pkg::*;

  // slot word: {used, key}
  logic [KEY_W:0]        mem [SLOTS];
  logic [KEY_W:0]        mem_q;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [KEY_W:0]        mem_wdata;

  state_t                state, state_next;
  logic [SIZE_W-1:0]     table_size;
  logic [SIZE_W-1:0]     live;
  logic [ADDR_W-1:0]     clr_cnt;

  kind_t                 op_kind;
  logic [KEY_W-1:0]      op_key;
  logic [DIV_W-1:0]      div_cnt;
  logic [SIZE_W-1:0]     rem;
  logic [SIZE_W-1:0]     rem_shift, rem_next;

  logic [ADDR_W-1:0]     s;
  logic [ADDR_W-1:0]     d;
  logic [SIZE_W-1:0]     issue_cnt;
  logic                  issue;
  logic                  rd_vld;
  logic                  rd_last;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  fwd_vld;
  logic [ADDR_W-1:0]     fwd_addr;
  logic                  hit;

  logic [SIZE_W-1:0]     s_sum, s_step;
  logic [SIZE_W-1:0]     d_sum, d_one, d_two;

  logic [KEY_W-1:0]      proc_key;
  logic                  proc_used;
  logic                  slot_free;
  logic                  slot_match;
  logic                  probe_done;
  logic                  wr_ins;
  logic                  wr_del;
  logic                  hit_next;
  status_t               done_status;
  logic [ADDR_W-1:0]     done_pos;

  status_t               res_status;
  logic [ADDR_W-1:0]     res_pos;
  logic                  out_load;
  logic                  accept;
  logic                  cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE[2]);
  assign prdata = (paddr[2] == REG_TABLE_SIZE[2]) ? {{(32-SIZE_W){1'b0}}, table_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
    end else if (cfg_wr) begin
      table_size <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    if (table_size == '0) begin
      live = SIZE_W'(1);
    end else if (table_size > SIZE_W'(SLOTS)) begin
      live = SIZE_W'(SLOTS);
    end else begin
      live = table_size;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[s];
  end

  // bit-serial modulo
  assign rem_shift = {rem[SIZE_W-2:0], op_key[div_cnt]};
  assign rem_next  = (rem_shift >= live) ? rem_shift - live : rem_shift;

  // probe step: s += (2i+1) mod n, d += 2 mod n
  assign s_sum  = {1'b0, s} + {1'b0, d};
  assign s_step = (s_sum >= live) ? s_sum - live : s_sum;
  assign d_sum  = {1'b0, d} + SIZE_W'(2);
  assign d_one  = (d_sum >= live) ? d_sum - live : d_sum;
  assign d_two  = (d_one >= live) ? d_one - live : d_one;

  assign issue = (state == ST_PROBE) && (issue_cnt <= live);

  // response processing
  assign proc_key   = (fwd_vld && (fwd_addr == rd_addr)) ? '0 : mem_q[KEY_W-1:0];
  assign proc_used  = mem_q[KEY_W];
  assign slot_free  = !proc_used || (proc_key == '0);
  assign slot_match = proc_used && (proc_key == op_key);

  always_comb begin
    probe_done  = 1'b0;
    wr_ins      = 1'b0;
    wr_del      = 1'b0;
    hit_next    = hit;
    done_status = STATUS_OK;
    done_pos    = '0;
    if (state == ST_PROBE && rd_vld) begin
      case (op_kind)
        KIND_INSERT: begin
          if (slot_free) begin
            wr_ins     = 1'b1;
            probe_done = 1'b1;
            done_pos   = rd_addr;
          end else if (rd_last) begin
            probe_done  = 1'b1;
            done_status = STATUS_FULL;
          end
        end
        KIND_FIND: begin
          if (!proc_used || rd_last || slot_match) begin
            probe_done = 1'b1;
          end
          if (slot_match) begin
            done_pos = rd_addr;
          end else begin
            done_status = STATUS_MISSING;
          end
        end
        KIND_DELETE: begin
          if (slot_match) begin
            wr_del   = 1'b1;
            hit_next = 1'b1;
          end
          if (!proc_used || rd_last) begin
            probe_done = 1'b1;
          end
          done_status = hit_next ? STATUS_OK : STATUS_MISSING;
        end
        default: begin
          probe_done = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr;
    mem_wdata = {1'b1, op_key};
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (wr_ins) begin
      mem_we = 1'b1;
    end else if (wr_del) begin
      mem_we    = 1'b1;
      mem_wdata = {1'b1, {KEY_W{1'b0}}};
    end
  end

  // handshakes
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == ST_RESULT) && (!out_valid || !out_stall);

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (kind_t'(kind) == KIND_NONE) ? ST_RESULT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (probe_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      rd_vld    <= 1'b0;
      fwd_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      rd_vld  <= issue && !probe_done;
      fwd_vld <= wr_del;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind    <= kind_t'(kind);
      op_key     <= key;
      div_cnt    <= DIV_W'(KEY_W - 1);
      rem        <= '0;
      hit        <= 1'b0;
      res_status <= STATUS_OK;
      res_pos    <= '0;
    end
    if (state == ST_DIV) begin
      rem     <= rem_next;
      div_cnt <= div_cnt - DIV_W'(1);
      if (div_cnt == '0) begin
        s         <= rem_next[ADDR_W-1:0];
        d         <= (live == SIZE_W'(1)) ? '0 : ADDR_W'(1);
        issue_cnt <= '0;
      end
    end
    if (issue) begin
      rd_addr   <= s;
      rd_last   <= (issue_cnt == live);
      s         <= s_step[ADDR_W-1:0];
      d         <= d_two[ADDR_W-1:0];
      issue_cnt <= issue_cnt + SIZE_W'(1);
    end
    fwd_addr <= rd_addr;
    if (state == ST_PROBE) begin
      hit <= hit_next;
      if (probe_done) begin
        res_status <= done_status;
        res_pos    <= done_pos;
      end
    end
    if (out_load) begin
      status   <= res_status;
      position <= res_pos;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for quadratic_probe_hash_set: a driver and a monitor on the word
// channels, an APB writer for table_size, and a model of the slot table that predicts each result.
// Depends on qph_pkg and the quadratic_probe_hash_set RTL.
module testbench;
  import qph_pkg::*;

  localparam int LONG_HOLD = 3000;

  typedef struct {
    kind_t             kind;
    logic [KEY_W-1:0]  key;
  } hash_req_t;

  typedef struct {
    status_t            status;
    logic [ADDR_W-1:0]  position;
  } hash_resp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         kind = '0;
  logic [KEY_W-1:0]   key = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [ADDR_W-1:0]  position;

  hash_req_t          pending_reqs[$];
  hash_resp_t         expected_resps[$];
  hash_resp_t         want;
  logic [KEY_W-1:0]   key_pool[$];

  bit [KEY_W-1:0]     model_keys[SLOTS];
  bit                 model_used[SLOTS];
  logic [SIZE_W-1:0]  size_reg = SIZE_RESET;

  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  bit                 send_pause = 1'b0;
  logic               hold_req = 1'b0;
  int unsigned        hold_left = 0;
  int unsigned        mismatches = 0;

  quadratic_probe_hash_set u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .position  (position)
  );

  always #5 clk = ~clk;

  // Applies one word to the slot table copy and returns the result it yields.
  function automatic hash_resp_t hash_set_apply(hash_req_t req);
    hash_resp_t         resp;
    int unsigned        n, home, i;
    logic [ADDR_W-1:0]  slot;
    bit                 hit;
    resp.status = STATUS_OK;
    resp.position = '0;
    hit = 1'b0;
    n = size_reg;
    if (n == 0) n = 1;
    if (n > SLOTS) n = SLOTS;
    home = req.key % n;
    case (req.kind)
      KIND_INSERT: begin
        resp.status = STATUS_FULL;
        for (i = 0; i <= n; i++) begin
          slot = ADDR_W'((home + i * i) % n);
          if (!model_used[slot] || model_keys[slot] == '0) begin
            model_keys[slot] = req.key;
            model_used[slot] = 1'b1;
            resp.status = STATUS_OK;
            resp.position = slot;
            break;
          end
        end
      end
      KIND_DELETE, KIND_FIND: begin
        for (i = 0; i <= n; i++) begin
          slot = ADDR_W'((home + i * i) % n);
          if (!model_used[slot]) break;
          if (model_keys[slot] == req.key) begin
            if (req.kind == KIND_DELETE) model_keys[slot] = '0;
            else if (!hit) resp.position = slot;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          resp.status = STATUS_MISSING;
          resp.position = '0;
        end
        if (req.kind == KIND_DELETE) resp.position = '0;
      end
      default: ;
    endcase
    return resp;
  endfunction

  // Driver: holds a stalled word, otherwise offers the next pending one or idles.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_resps.push_back(hash_set_apply(pending_reqs.pop_front()));
      if (pending_reqs.size() != 0 && !send_pause &&
          $urandom_range(99) >= send_idle_pct) begin
        kind <= pending_reqs[0].kind;
        key <= pending_reqs[0].key;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_req) hold_left <= LONG_HOLD;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_resps.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: status %0d position %0d", status, position);
        mismatches++;
      end else begin
        want = expected_resps.pop_front();
        if (status !== want.status || position !== want.position) begin
          if (mismatches < 10)
            $display("mismatch: status exp %0d got %0d, position exp %0d got %0d",
                     want.status, status, want.position, position);
          mismatches++;
        end
      end
    end
  end

  task automatic write_size(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_TABLE_SIZE;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    size_reg = value[SIZE_W-1:0];
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0);
  endtask

  task automatic push_req(input kind_t k, input logic [KEY_W-1:0] v);
    hash_req_t req;
    req.kind = k;
    req.key = v;
    pending_reqs.push_back(req);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int unsigned n);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40 && key_pool.size() != 0) return key_pool[$urandom_range(key_pool.size() - 1)];
    if (r < 70) return KEY_W'($urandom_range(4 * n));
    if (r < 80) return KEY_W'(32'h7fff_ff00 | $urandom_range(255));
    return KEY_W'($urandom);
  endfunction

  // A random mix weighted toward inserts, with deletes, lookups and some no-op words; keys partly from recent inserts.
  task automatic push_random(input int count);
    int unsigned       n, r;
    logic [KEY_W-1:0]  v;
    n = (size_reg == 0) ? 1 : (size_reg > SLOTS) ? SLOTS : size_reg;
    for (int c = 0; c < count; c++) begin
      r = $urandom_range(99);
      v = pick_key(n);
      if (r < 45) begin
        push_req(KIND_INSERT, v);
        key_pool.push_back(v);
        if (key_pool.size() > 32) void'(key_pool.pop_front());
      end else if (r < 70) begin
        push_req(KIND_DELETE, v);
      end else if (r < 95) begin
        push_req(KIND_FIND, v);
      end else begin
        push_req(KIND_NONE, v);
      end
    end
  endtask

  initial begin
    #50_000_000;
    $display("quadratic_probe_hash_set test failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 86;
    @(negedge clk);
    // reset size, collisions, tombstones, key zero, unused kind
    push_req(KIND_INSERT, 31'd1);
    push_req(KIND_INSERT, 31'h7fff_ffff);
    push_req(KIND_INSERT, 31'd1025);
    push_req(KIND_FIND, 31'd1025);
    push_req(KIND_FIND, 31'd1);
    push_req(KIND_DELETE, 31'd1);
    push_req(KIND_FIND, 31'd1025);
    push_req(KIND_FIND, 31'd1);
    push_req(KIND_INSERT, 31'd0);
    push_req(KIND_FIND, 31'd0);
    push_req(KIND_DELETE, 31'd0);
    push_req(KIND_NONE, 31'h7fff_ffff);
    push_req(KIND_INSERT, 31'd1);
    wait_idle();
    // size zero acts as one slot
    write_size(32'd0);
    @(negedge clk);
    push_req(KIND_INSERT, 31'd5);
    push_req(KIND_INSERT, 31'd6);
    push_req(KIND_FIND, 31'd5);
    push_req(KIND_DELETE, 31'd5);
    push_req(KIND_INSERT, 31'd6);
    push_req(KIND_FIND, 31'd9);
    wait_idle();
    // oversize clamps to the full table
    write_size(32'd2047);
    @(negedge clk);
    push_req(KIND_FIND, 31'h7fff_ffff);
    push_req(KIND_DELETE, 31'h7fff_ffff);
    push_req(KIND_FIND, 31'h7fff_ffff);
    push_req(KIND_NONE, 31'd0);
    wait_idle();

    write_size(32'd7);
    push_random(90);
    wait_idle();
    write_size(32'd16);
    push_random(80);
    wait_idle();

    send_idle_pct = 86;
    recv_idle_pct = 11;
    write_size(32'd1);
    push_random(40);
    wait_idle();
    write_size(32'd13);
    push_random(100);
    do @(negedge clk); while (pending_reqs.size() > 50);
    send_pause = 1'b1;
    do @(negedge clk); while (in_valid || expected_resps.size() != 0);
    send_pause = 1'b0;
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_size(32'd1024);
    @(posedge clk);
    hold_req <= 1'b1;
    do @(negedge clk); while (hold_left == 0);
    push_random(40);
    @(posedge clk);
    hold_req <= 1'b0;
    wait_idle();
    write_size(32'd64);
    push_random(130);
    wait_idle();
    write_size(32'd3);
    push_random(60);
    wait_idle();
    write_size(32'd1023);
    push_random(40);
    wait_idle();

    repeat (1100) @(posedge clk);
    if (expected_resps.size() != 0) begin
      if (mismatches < 10) $display("%0d expected words never arrived", expected_resps.size());
      mismatches++;
    end
    if (mismatches == 0) $display("quadratic_probe_hash_set test passed");
    else $display("quadratic_probe_hash_set test failed");
    $finish;
  end

endmodule
